// ===== hdl/cqf_pkg.sv =====
package cqf_pkg;

  localparam int DATA_W        = 32;
  localparam int DEFAULT_DEPTH = 8;

  localparam logic [1:0] CMD_INSERT  = 2'd0;
  localparam logic [1:0] CMD_DELETE  = 2'd1;
  localparam logic [1:0] CMD_DISPLAY = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OVERFLOW = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;

  typedef struct packed {
    logic [1:0]               cmd;
    logic signed [DATA_W-1:0] data_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [DATA_W-1:0] out_value;
    logic                     last;
  } out_item_t;

  typedef struct packed {
    logic       emit;
    logic [1:0] emit_status;
    logic       emit_ram;
    logic       emit_last;
    logic       insert;
    logic       remove;
    logic       walk_load;
    logic       walk_step;
  } dp_cmd_t;

  typedef struct packed {
    logic is_empty;
    logic is_full;
    logic walk_at_tail;
  } dp_stat_t;

endpackage

// ===== hdl/cqf_ram.sv =====
module cqf_ram
  import cqf_pkg::*;
#(
  parameter int WIDTH = DATA_W,
  parameter int DEPTH = DEFAULT_DEPTH
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/cqf_ctrl.sv =====
module cqf_ctrl
  import cqf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [1:0] cmd,
  input  dp_stat_t   stat,
  output dp_cmd_t    ctl,
  output logic       busy
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DEL,
    S_DISP
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  always_comb begin
    ctl        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (cmd)
            CMD_INSERT: begin
              ctl.emit      = 1'b1;
              ctl.emit_last = 1'b1;
              if (stat.is_full) begin
                ctl.emit_status = ST_OVERFLOW;
              end else begin
                ctl.emit_status = ST_OK;
                ctl.insert      = 1'b1;
              end
            end
            CMD_DELETE: begin
              if (stat.is_empty) begin
                ctl.emit        = 1'b1;
                ctl.emit_status = ST_EMPTY;
                ctl.emit_last   = 1'b1;
              end else begin
                ctl.remove = 1'b1;
                state_next = S_DEL;
              end
            end
            CMD_DISPLAY: begin
              if (stat.is_empty) begin
                ctl.emit        = 1'b1;
                ctl.emit_status = ST_EMPTY;
                ctl.emit_last   = 1'b1;
              end else begin
                ctl.walk_load = 1'b1;
                state_next    = S_DISP;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_DEL: begin
        ctl.emit        = 1'b1;
        ctl.emit_status = ST_OK;
        ctl.emit_ram    = 1'b1;
        ctl.emit_last   = 1'b1;
        state_next      = S_IDLE;
      end
      S_DISP: begin
        ctl.emit        = 1'b1;
        ctl.emit_status = ST_OK;
        ctl.emit_ram    = 1'b1;
        ctl.emit_last   = stat.walk_at_tail;
        ctl.walk_step   = 1'b1;
        if (stat.walk_at_tail) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_del_one_beat: assert property (@(posedge clk) disable iff (rst)
    state == S_DEL |=> state == S_IDLE)
    else $error("delete readout did not return to idle");

  a_disp_holds: assert property (@(posedge clk) disable iff (rst)
    (state == S_DISP && !stat.walk_at_tail) |=> state == S_DISP)
    else $error("display walk ended before the tail");

  a_disp_ends: assert property (@(posedge clk) disable iff (rst)
    (state == S_DISP && stat.walk_at_tail) |=> state == S_IDLE)
    else $error("display walk ran past the tail");

endmodule

// ===== hdl/cqf_dp.sv =====
module cqf_dp
  import cqf_pkg::*;
#(
  parameter int DEPTH = DEFAULT_DEPTH
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic signed [DATA_W-1:0] data_value,
  input  dp_cmd_t                  ctl,
  output dp_stat_t                 stat,
  output out_item_t                result,
  output logic                     strobe
);

  localparam int IW = $clog2(DEPTH);

  logic [IW-1:0]     head;
  logic [IW-1:0]     tail;
  logic [IW-1:0]     walk;
  logic              is_empty;
  logic [IW-1:0]     tail_inc;
  logic [IW-1:0]     head_inc;
  logic [IW-1:0]     walk_inc;
  logic              ram_we;
  logic [IW-1:0]     ram_waddr;
  logic [IW-1:0]     ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  function automatic logic [IW-1:0] next_idx(input logic [IW-1:0] i);
    return (i == IW'(DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  assign tail_inc = next_idx(tail);
  assign head_inc = next_idx(head);
  assign walk_inc = next_idx(walk);

  assign stat.is_empty     = is_empty;
  assign stat.is_full      = !is_empty && (tail_inc == head);
  assign stat.walk_at_tail = (walk == tail);

  assign ram_we    = ctl.insert;
  assign ram_waddr = is_empty ? '0 : tail_inc;
  assign ram_raddr = ctl.walk_step ? walk_inc : head;

  cqf_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata ($unsigned(data_value)),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      tail     <= '0;
      is_empty <= 1'b1;
    end else if (ctl.insert) begin
      if (is_empty) begin
        head     <= '0;
        tail     <= '0;
        is_empty <= 1'b0;
      end else begin
        tail <= tail_inc;
      end
    end else if (ctl.remove) begin
      if (head == tail) begin
        head     <= '0;
        tail     <= '0;
        is_empty <= 1'b1;
      end else begin
        head <= head_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.walk_load) begin
      walk <= head;
    end else if (ctl.walk_step) begin
      walk <= walk_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= ctl.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      result.status    <= ctl.emit_status;
      result.out_value <= ctl.emit_ram ? $signed(ram_rdata) : '0;
      result.last      <= ctl.emit_last;
    end
  end

  a_empty_at_zero: assert property (@(posedge clk) disable iff (rst)
    is_empty |-> (head == '0 && tail == '0))
    else $error("empty queue with indices away from slot zero");

  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    (strobe && result.status == ST_OVERFLOW) |-> stat.is_full)
    else $error("overflow reported on a queue that is not full");

  a_partial_ok: assert property (@(posedge clk) disable iff (rst)
    (strobe && !result.last) |-> result.status == ST_OK)
    else $error("non-final beat with an error status");

endmodule

// ===== hdl/circular_queue_fifo_unit.sv =====
// Circular queue of DEPTH signed 32-bit words. A command is taken when start is high and
// busy is low. Busy stays low for an insert, so inserts, overflows and empty replies can
// follow every cycle; each gives one result beat on the cycle after it is taken. Delete
// holds busy through a readout state, set by the registered read port of the slot memory:
// the word comes out in the cycle after the read is issued. Display gives one beat per stored
// word, one memory read per beat, oldest first, with last on the newest word. Code 3 is
// dropped with no beat. Result beats are shown on result for one cycle with strobe high and
// must be captured then: there is no way to hold them off. No clearing pass after reset.
module circular_queue_fifo_unit
  import cqf_pkg::*;
#(
  parameter int DEPTH = DEFAULT_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  in_item_t  request,
  output logic      busy,
  output logic      strobe,
  output out_item_t result
);

  dp_cmd_t  ctl;
  dp_stat_t stat;

  cqf_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .cmd   (request.cmd),
    .stat  (stat),
    .ctl   (ctl),
    .busy  (busy)
  );

  cqf_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .data_value (request.data_value),
    .ctl        (ctl),
    .stat       (stat),
    .result     (result),
    .strobe     (strobe)
  );

endmodule

// ===== tb/circular_queue_fifo_unit_tb.sv =====
`timescale 1ns / 1ps

module circular_queue_fifo_unit_tb;
  import cqf_pkg::*;

  localparam int DEPTH = DEFAULT_DEPTH;
  localparam int CLK_HALF = 5;
  localparam int RESET_CYC = 8;
  localparam int RANDOM_CMDS = 380;
  localparam int STALL_LIMIT = 200;
  localparam int TAIL_CYC = 16;
  localparam logic [1:0] CMD_IGNORED = 2'd3;

  typedef struct {
    in_item_t item;
    int       gap;
    bit       drain;
  } pending_cmd_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      start = 1'b0;
  in_item_t  request = '0;
  logic      busy;
  logic      strobe;
  out_item_t result;

  pending_cmd_t cmd_q[$];
  out_item_t    beat_q[$];

  // predicted ring state
  logic signed [DATA_W-1:0] ring_mem[DEPTH];
  int unsigned              ring_head = 0;
  int unsigned              ring_tail = 0;
  bit                       ring_empty = 1'b1;

  pending_cmd_t cur;
  bit           loaded = 1'b0;
  int           wait_cnt = 0;
  logic         took_beat = 1'b0;
  logic         all_done = 1'b0;
  int           idle_cycles = 0;
  int           errors = 0;
  int           n_insert = 0, n_delete = 0, n_display = 0, n_ignored = 0;
  int           n_beats = 0, n_overflow = 0, n_empty = 0, n_full_display = 0;

  circular_queue_fifo_unit #(
    .DEPTH(DEPTH)
  ) u_top (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .request(request),
    .busy   (busy),
    .strobe (strobe),
    .result (result)
  );

  always #(CLK_HALF) clk = ~clk;

  function automatic int unsigned ring_next(int unsigned i);
    return (i + 1 >= DEPTH) ? 0 : i + 1;
  endfunction

  function automatic void ring_apply(in_item_t it);
    out_item_t   r;
    int unsigned cnt;
    int unsigned idx;
    r = '0;
    r.last = 1'b1;
    case (it.cmd)
      CMD_INSERT: begin
        n_insert++;
        if (ring_empty) begin
          ring_head = 0;
          ring_tail = 0;
          ring_mem[0] = it.data_value;
          ring_empty = 1'b0;
        end else if (ring_next(ring_tail) == ring_head) begin
          r.status = ST_OVERFLOW;
          n_overflow++;
        end else begin
          ring_tail = ring_next(ring_tail);
          ring_mem[ring_tail] = it.data_value;
        end
        beat_q.push_back(r);
      end
      CMD_DELETE: begin
        n_delete++;
        if (ring_empty) begin
          r.status = ST_EMPTY;
          n_empty++;
        end else begin
          r.out_value = ring_mem[ring_head];
          if (ring_head == ring_tail) begin
            ring_head = 0;
            ring_tail = 0;
            ring_empty = 1'b1;
          end else begin
            ring_head = ring_next(ring_head);
          end
        end
        beat_q.push_back(r);
      end
      CMD_DISPLAY: begin
        n_display++;
        if (ring_empty) begin
          r.status = ST_EMPTY;
          n_empty++;
          beat_q.push_back(r);
        end else begin
          if (ring_head <= ring_tail) cnt = ring_tail - ring_head + 1;
          else cnt = DEPTH - ring_head + ring_tail + 1;
          if (cnt == DEPTH) n_full_display++;
          idx = ring_head;
          for (int unsigned i = 0; i < cnt; i++) begin
            r.out_value = ring_mem[idx];
            r.last = (i + 1 == cnt);
            beat_q.push_back(r);
            idx = ring_next(idx);
          end
        end
      end
      default: n_ignored++;
    endcase
  endfunction

  function automatic logic signed [DATA_W-1:0] rand_word();
    case ($urandom_range(0, 15))
      0: return {1'b1, {(DATA_W-1){1'b0}}};
      1: return {1'b0, {(DATA_W-1){1'b1}}};
      2: return '1;
      3: return '0;
      default: return $urandom;
    endcase
  endfunction

  function automatic void queue_cmd(logic [1:0] c, logic signed [DATA_W-1:0] d, int gap,
                                    bit drain);
    pending_cmd_t p;
    p.item.cmd = c;
    p.item.data_value = d;
    p.gap = gap;
    p.drain = drain;
    cmd_q.push_back(p);
  endfunction

  // driver
  always @(negedge clk) begin : drv
    logic nxt_start;
    nxt_start = start;
    if (rst) begin
      nxt_start = 1'b0;
    end else begin
      if (start && took_beat) nxt_start = 1'b0;
      if (!nxt_start) begin
        if (!loaded && cmd_q.size() > 0) begin
          cur = cmd_q.pop_front();
          loaded = 1'b1;
          wait_cnt = cur.gap;
        end
        if (loaded) begin
          if (wait_cnt > 0) begin
            wait_cnt--;
          end else if (!cur.drain || beat_q.size() == 0) begin
            nxt_start = 1'b1;
            request <= cur.item;
            loaded = 1'b0;
          end
        end
      end
    end
    start <= nxt_start;
  end

  // monitor and checker
  always @(posedge clk) begin : mon
    out_item_t got;
    out_item_t want;
    took_beat <= !rst && start && !busy;
    if (!rst && strobe) begin
      got = result;
      n_beats++;
      if (beat_q.size() == 0) begin
        $display("%0t: beat with nothing expected: status %0d value %0d last %0b",
                 $time, got.status, got.out_value, got.last);
        errors++;
      end else begin
        want = beat_q.pop_front();
        if (got.status !== want.status) begin
          $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
          errors++;
        end
        if (got.out_value !== want.out_value) begin
          $display("%0t: out_value expected %0d got %0d", $time, want.out_value,
                   got.out_value);
          errors++;
        end
        if (got.last !== want.last) begin
          $display("%0t: last expected %0b got %0b", $time, want.last, got.last);
          errors++;
        end
      end
    end
    if (!rst && start && !busy) ring_apply(request);
    if (rst || (start && !busy)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    all_done <= !rst && cmd_q.size() == 0 && !loaded && !start && beat_q.size() == 0;
  end

  initial begin
    int real_cnt;
    int seg_len;
    int k;
    int bias;
    int gap_mode;
    int roll;
    int ins_limit;
    int gap;
    logic [1:0] c;

    // directed: empty replies, ignored code, extremes, fill, overflow, full and wrapped views
    queue_cmd(CMD_DISPLAY, '0, 0, 1'b0);
    queue_cmd(CMD_DELETE, '1, 0, 1'b0);
    queue_cmd(CMD_IGNORED, 32'h1234_5678, 0, 1'b0);
    queue_cmd(CMD_INSERT, 32'h8000_0000, 0, 1'b0);
    queue_cmd(CMD_INSERT, 32'h7fff_ffff, 0, 1'b0);
    queue_cmd(CMD_INSERT, '1, 0, 1'b0);
    queue_cmd(CMD_INSERT, '0, 0, 1'b0);
    queue_cmd(CMD_INSERT, 32'h5555_5555, 0, 1'b0);
    queue_cmd(CMD_INSERT, 32'haaaa_aaaa, 0, 1'b0);
    queue_cmd(CMD_INSERT, 32'h0000_0001, 0, 1'b0);
    queue_cmd(CMD_INSERT, rand_word(), 0, 1'b0);
    queue_cmd(CMD_INSERT, 32'hdead_beef, 0, 1'b0);
    queue_cmd(CMD_DISPLAY, '0, 0, 1'b0);
    queue_cmd(CMD_DELETE, '0, 0, 1'b0);
    queue_cmd(CMD_DELETE, '0, 0, 1'b0);
    queue_cmd(CMD_DELETE, '0, 0, 1'b0);
    queue_cmd(CMD_INSERT, 32'hffff_0000, 0, 1'b0);
    queue_cmd(CMD_INSERT, 32'h0000_ffff, 0, 1'b0);
    queue_cmd(CMD_DISPLAY, '0, 0, 1'b0);
    queue_cmd(CMD_DELETE, '0, 3, 1'b1);

    real_cnt = 0;
    while (real_cnt < RANDOM_CMDS) begin
      seg_len = $urandom_range(20, 60);
      bias = $urandom_range(0, 2);
      gap_mode = $urandom_range(0, 2);
      ins_limit = (bias == 0) ? 78 : (bias == 1) ? 43 : 59;
      for (k = 0; k < seg_len && real_cnt < RANDOM_CMDS; k++) begin
        roll = $urandom_range(0, 99);
        if (roll < 3) c = CMD_IGNORED;
        else if (roll < 18) c = CMD_DISPLAY;
        else if (roll < ins_limit) c = CMD_INSERT;
        else c = CMD_DELETE;
        if (gap_mode == 0) gap = 0;
        else if (gap_mode == 1) gap = $urandom_range(0, 12);
        else gap = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 12) : 0;
        queue_cmd(c, rand_word(), gap, k == 0 && $urandom_range(0, 3) == 0);
        if (c != CMD_IGNORED) real_cnt++;
      end
    end

    repeat (RESET_CYC) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    @(negedge clk);
    while (!all_done && idle_cycles < STALL_LIMIT) @(negedge clk);
    if (!all_done) begin
      $display("%0t: no progress for %0d cycles, %0d beats still expected", $time,
               idle_cycles, beat_q.size());
      $display("circular_queue_fifo_unit test failed");
      $finish;
    end else begin
      repeat (TAIL_CYC) @(negedge clk);
      $display("ran %0d inserts, %0d deletes, %0d displays, %0d ignored codes",
               n_insert, n_delete, n_display, n_ignored);
      $display("checked %0d beats: %0d overflow, %0d empty, %0d full-depth displays",
               n_beats, n_overflow, n_empty, n_full_display);
      if (errors == 0 && beat_q.size() == 0) begin
        $display("circular_queue_fifo_unit test passed");
      end else begin
        $display("circular_queue_fifo_unit test failed");
      end
      $finish;
    end
  end

endmodule

// ===== circular_queue_fifo_unit.f =====
hdl/cqf_pkg.sv
hdl/cqf_ram.sv
hdl/cqf_ctrl.sv
hdl/cqf_dp.sv
hdl/circular_queue_fifo_unit.sv
tb/circular_queue_fifo_unit_tb.sv
